/* src/compass_heading_minmax_calibrated_unit_assert.svh */
// Assertion macros for the compass heading unit.
`ifndef COMPASS_HEADING_MINMAX_CALIBRATED_UNIT_ASSERT_SVH
`define COMPASS_HEADING_MINMAX_CALIBRATED_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst_n, ante, cons)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/chmc_pkg.sv */
// Shared constants and functions for the compass heading unit.
package chmc_pkg;
    localparam int SampleBitsDef   = 16;
    localparam int CordicStagesDef = 16;
    localparam int AngBits   = 34;
    localparam int ScaleBits = 19;
    localparam int HeadBits  = 15;
    localparam logic signed [AngBits-1:0] Ang90 = 34'sd5898240;
    localparam logic signed [HeadBits-1:0] HeadMax = 15'sd11520;
    localparam logic [2:0] RegXLo = 3'd0;
    localparam logic [2:0] RegXHi = 3'd1;
    localparam logic [2:0] RegYLo = 3'd2;
    localparam logic [2:0] RegYHi = 3'd3;
    localparam logic [2:0] RegZLo = 3'd4;
    localparam logic [2:0] RegZHi = 3'd5;
    localparam logic [2:0] RegCal = 3'd6;

    function automatic logic signed [AngBits-1:0] arc_of(input int idx);
        logic signed [AngBits-1:0] v;
        case (idx)
            0: v = 34'sd2949120;  1: v = 34'sd1740967;  2: v = 34'sd919879;
            3: v = 34'sd466945;   4: v = 34'sd234379;   5: v = 34'sd117304;
            6: v = 34'sd58666;    7: v = 34'sd29335;    8: v = 34'sd14668;
            9: v = 34'sd7334;     10: v = 34'sd3667;    11: v = 34'sd1833;
            12: v = 34'sd917;     13: v = 34'sd458;     14: v = 34'sd229;
            15: v = 34'sd115;     16: v = 34'sd57;      17: v = 34'sd29;
            18: v = 34'sd14;      19: v = 34'sd7;       20: v = 34'sd4;
            21: v = 34'sd2;       22: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

/* src/chmc_div_cell.sv */
// One restoring-division cell of the scale divider chain: one quotient bit per cell.
module chmc_div_cell #(
    parameter int NumBits = 42,
    parameter int DenBits = 20,
    parameter int SideBits = 40,
    parameter int BitIdx = 0
) (
    input  logic                i_clk,
    input  logic                i_vld,
    input  logic [NumBits-1:0]  i_num,
    input  logic [DenBits-1:0]  i_den,
    input  logic [NumBits-1:0]  i_rem,
    input  logic [NumBits-1:0]  i_quo,
    input  logic [SideBits-1:0] i_side,
    output logic                o_vld,
    output logic [NumBits-1:0]  o_num,
    output logic [DenBits-1:0]  o_den,
    output logic [NumBits-1:0]  o_rem,
    output logic [NumBits-1:0]  o_quo,
    output logic [SideBits-1:0] o_side
);
    logic [NumBits:0] n_trial;
    logic [NumBits-1:0] n_rem;
    logic               n_bit;
    always_comb begin
        n_trial = {i_rem, i_num[BitIdx]};
        if (n_trial >= {{(NumBits+1-DenBits){1'b0}}, i_den}) begin
            n_rem = NumBits'(n_trial - {{(NumBits+1-DenBits){1'b0}}, i_den});
            n_bit = 1'b1;
        end else begin
            n_rem = n_trial[NumBits-1:0];
            n_bit = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        o_vld  <= i_vld;
        o_num  <= i_num;
        o_den  <= i_den;
        o_rem  <= n_rem;
        o_quo  <= i_quo | (NumBits'(n_bit) << BitIdx);
        o_side <= i_side;
    end
endmodule

/* src/chmc_cordic_cell.sv */
// One CORDIC vectoring cell: a micro-rotation by a fixed arctangent.
module chmc_cordic_cell #(
    parameter int VecBits = 40,
    parameter int Stage = 0
) (
    input  logic                       i_clk,
    input  logic                       i_vld,
    input  logic signed [VecBits-1:0]  i_a,
    input  logic signed [VecBits-1:0]  i_b,
    input  logic signed [chmc_pkg::AngBits-1:0] i_z,
    input  logic [1:0]                 i_flags,
    output logic                       o_vld,
    output logic signed [VecBits-1:0]  o_a,
    output logic signed [VecBits-1:0]  o_b,
    output logic signed [chmc_pkg::AngBits-1:0] o_z,
    output logic [1:0]                 o_flags
);
    import chmc_pkg::*;

    logic signed [VecBits-1:0] n_da, n_db;
    always_comb begin
        n_da = i_b >>> Stage;
        n_db = i_a >>> Stage;
    end
    always_ff @(posedge i_clk) begin
        o_vld   <= i_vld;
        o_flags <= i_flags;
        if (!i_b[VecBits-1]) begin
            o_a <= i_a + n_da;
            o_b <= i_b - n_db;
            o_z <= i_z + arc_of(Stage);
        end else begin
            o_a <= i_a - n_da;
            o_b <= i_b + n_db;
            o_z <= i_z - arc_of(Stage);
        end
    end
endmodule

/* src/compass_heading_minmax_calibrated_unit.sv */
// Top level of the calibrated compass heading unit.
//  channel | ports                                   | handshake
//  sample  | i_start, i_field_x, i_field_y, o_busy   | start & !busy
//  result  | o_done, o_heading, o_span_fault         | strobe, one cycle
//  config  | psel penable pwrite paddr pwdata prdata | APB, pready high
// One sample enters per cycle; each passes a row of cells: 3 prep stages,
// 36 divider cells, a saturation stage, a multiply stage, a prerotation,
// CORDIC_STAGES cells and 1 rounding stage: 43 + CORDIC_STAGES registers.
// Reset is synchronous, clears valid bits and loads the config registers with defaults. busy stays low.
module compass_heading_minmax_calibrated_unit #(
    parameter int SAMPLE_BITS   = chmc_pkg::SampleBitsDef,
    parameter int CORDIC_STAGES = chmc_pkg::CordicStagesDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_field_x,
    input  logic signed [SAMPLE_BITS-1:0] i_field_y,
    output logic                   o_busy,
    output logic                   o_done,
    output logic signed [chmc_pkg::HeadBits-1:0] o_heading,
    output logic                   o_span_fault,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import chmc_pkg::*;
    `include "compass_heading_minmax_calibrated_unit_assert.svh"

    localparam int SB = SAMPLE_BITS;
    localparam int HB = SB + 1;           // half-span
    localparam int SumB = SB + 3;
    localparam int NumB = SumB + 16;      // |sum|*65536 fits
    localparam int DenB = HB + 4;         // 2*3*|half|
    localparam int DivB = NumB + 1;
    localparam int DiffB = SB + 2;
    localparam int ProdB = DiffB + ScaleBits;
    localparam int VecB = ProdB + 3;
    localparam int SideB = 2 * DiffB + 3; // diffs, fault, cal, zero flag

    logic signed [SB-1:0] r_xl, r_xh, r_yl, r_yh, r_zl, r_zh;
    logic                 r_cal;
    logic                 w_wr;
    logic [2:0]           w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xl <= SB'(-7912); r_xh <= SB'(-1648);
            r_yl <= SB'(-6554); r_yh <= SB'(-528);
            r_zl <= SB'(-3074); r_zh <= SB'(2720);
            r_cal <= 1'b1;
        end else if (w_wr) begin
            unique case (w_idx)
                RegXLo: r_xl <= pwdata[SB-1:0];
                RegXHi: r_xh <= pwdata[SB-1:0];
                RegYLo: r_yl <= pwdata[SB-1:0];
                RegYHi: r_yh <= pwdata[SB-1:0];
                RegZLo: r_zl <= pwdata[SB-1:0];
                RegZHi: r_zh <= pwdata[SB-1:0];
                RegCal: r_cal <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            RegXLo: prdata = 32'(signed'(r_xl));
            RegXHi: prdata = 32'(signed'(r_xh));
            RegYLo: prdata = 32'(signed'(r_yl));
            RegYHi: prdata = 32'(signed'(r_yh));
            RegZLo: prdata = 32'(signed'(r_zl));
            RegZHi: prdata = 32'(signed'(r_zh));
            RegCal: prdata = {31'd0, r_cal};
            default: prdata = '0;
        endcase
    end

    // truncating divide by two
    function automatic logic signed [HB-1:0] half_of(input logic signed [HB-1:0] v);
        logic signed [HB-1:0] t;
        t = v + HB'(v[HB-1]);
        return t >>> 1;
    endfunction

    // stage 1: half-spans, centres, diffs
    logic r1_vld, r1_cal;
    logic signed [HB-1:0] r1_hx, r1_hy, r1_hz;
    logic signed [DiffB-1:0] r1_dx, r1_dy;
    logic signed [SB-1:0] r1_sx, r1_sy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else r1_vld <= i_start;
        r1_cal <= r_cal;
        r1_hx <= half_of(HB'(r_xh) - HB'(r_xl));
        r1_hy <= half_of(HB'(r_yh) - HB'(r_yl));
        r1_hz <= half_of(HB'(r_zh) - HB'(r_zl));
        r1_dx <= DiffB'(i_field_x) - DiffB'(half_of(HB'(r_xl) + HB'(r_xh)));
        r1_dy <= DiffB'(i_field_y) - DiffB'(half_of(HB'(r_yl) + HB'(r_yh)));
        r1_sx <= i_field_x;
        r1_sy <= i_field_y;
    end

    // stage 2: sum and fault; raw mode substitutes samples for diffs
    logic r2_vld, r2_cal, r2_flt;
    logic signed [SumB-1:0] r2_sum;
    logic signed [HB-1:0] r2_hx, r2_hy;
    logic signed [DiffB-1:0] r2_dx, r2_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else r2_vld <= r1_vld;
        r2_cal <= r1_cal;
        r2_flt <= r1_cal && (r1_hx == '0 || r1_hy == '0);
        r2_sum <= SumB'(r1_hx) + SumB'(r1_hy) + SumB'(r1_hz);
        r2_hx <= r1_hx;
        r2_hy <= r1_hy;
        r2_dx <= r1_cal ? r1_dx : DiffB'(r1_sx);
        r2_dy <= r1_cal ? r1_dy : DiffB'(r1_sy);
    end

    // stage 3: magnitudes for the two divider rows; numerator 2n+d, divisor 2d
    logic r3_vld;
    logic [DivB-1:0] r3_nx, r3_ny;
    logic [DenB-1:0] r3_gx, r3_gy;
    logic [SideB-1:0] r3_side;
    logic r3_negx, r3_negy;
    logic [NumB-1:0] w_n;
    logic [DenB-1:0] w_dx, w_dy;
    logic signed [SumB-1:0] w_as;
    logic signed [HB-1:0] w_ahx, w_ahy;
    always_comb begin
        w_as  = r2_sum[SumB-1] ? -r2_sum : r2_sum;
        w_ahx = r2_hx[HB-1] ? -r2_hx : r2_hx;
        w_ahy = r2_hy[HB-1] ? -r2_hy : r2_hy;
        w_n   = NumB'(w_as) << 16;
        w_dx  = DenB'(w_ahx) * DenB'(3);
        w_dy  = DenB'(w_ahy) * DenB'(3);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else r3_vld <= r2_vld;
        r3_nx <= (DivB'(w_n) << 1) + DivB'(w_dx);
        r3_ny <= (DivB'(w_n) << 1) + DivB'(w_dy);
        r3_gx <= w_dx << 1;
        r3_gy <= w_dy << 1;
        r3_negx <= r2_sum[SumB-1] ^ r2_hx[HB-1];
        r3_negy <= r2_sum[SumB-1] ^ r2_hy[HB-1];
        r3_side <= {r2_dx, r2_dy, r2_flt, r2_cal, 1'b0};
    end

    // divider chains, MSB first
    logic            dv_vld [0:DivB];
    logic [DivB-1:0] dx_num [0:DivB], dx_rem [0:DivB], dx_quo [0:DivB];
    logic [DivB-1:0] dy_num [0:DivB], dy_rem [0:DivB], dy_quo [0:DivB];
    logic [DenB-1:0] dx_den [0:DivB], dy_den [0:DivB];
    logic [SideB-1:0] dx_side [0:DivB];
    logic [1:0]       dy_side [0:DivB];
    logic            dy_vld [0:DivB];
    assign dv_vld[0] = r3_vld;  assign dy_vld[0] = r3_vld;
    assign dx_num[0] = r3_nx;   assign dy_num[0] = r3_ny;
    assign dx_den[0] = r3_gx;   assign dy_den[0] = r3_gy;
    assign dx_rem[0] = '0;      assign dy_rem[0] = '0;
    assign dx_quo[0] = '0;      assign dy_quo[0] = '0;
    assign dx_side[0] = r3_side;
    assign dy_side[0] = {r3_negx, r3_negy};
    for (genvar g = 0; g < DivB; g++) begin : g_div
        chmc_div_cell #(.NumBits(DivB), .DenBits(DenB), .SideBits(SideB),
                        .BitIdx(DivB - 1 - g)) u_dx (
            .i_clk, .i_vld(dv_vld[g]), .i_num(dx_num[g]), .i_den(dx_den[g]),
            .i_rem(dx_rem[g]), .i_quo(dx_quo[g]), .i_side(dx_side[g]),
            .o_vld(dv_vld[g+1]), .o_num(dx_num[g+1]), .o_den(dx_den[g+1]),
            .o_rem(dx_rem[g+1]), .o_quo(dx_quo[g+1]), .o_side(dx_side[g+1]));
        chmc_div_cell #(.NumBits(DivB), .DenBits(DenB), .SideBits(2),
                        .BitIdx(DivB - 1 - g)) u_dy (
            .i_clk, .i_vld(dy_vld[g]), .i_num(dy_num[g]), .i_den(dy_den[g]),
            .i_rem(dy_rem[g]), .i_quo(dy_quo[g]), .i_side(dy_side[g]),
            .o_vld(dy_vld[g+1]), .o_num(dy_num[g+1]), .o_den(dy_den[g+1]),
            .o_rem(dy_rem[g+1]), .o_quo(dy_quo[g+1]), .o_side(dy_side[g+1]));
    end

    // the divider cells carry no reset; gate their valid with a reset-cleared shadow
    logic [DivB-1:0] r_vsh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vsh <= '0;
        else r_vsh <= {r_vsh[DivB-2:0], r3_vld};
    end

    // stage M1: signed, saturated scales
    logic rm1_vld, rm1_flt, rm1_cal;
    logic signed [ScaleBits-1:0] rm1_kx, rm1_ky;
    logic signed [DiffB-1:0] rm1_dx, rm1_dy;
    function automatic logic signed [ScaleBits-1:0] sat_of(input logic [DivB-1:0] q,
                                                           input logic neg);
        logic signed [ScaleBits-1:0] v;
        if (neg) v = (q > DivB'(262144)) ? -19'sd262144 : -ScaleBits'(q);
        else v = (q > DivB'(262143)) ? 19'sd262143 : ScaleBits'(q);
        return v;
    endfunction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rm1_vld <= 1'b0;
        else rm1_vld <= r_vsh[DivB-1] && dv_vld[DivB] && dy_vld[DivB];
        rm1_kx <= sat_of(dx_quo[DivB], dy_side[DivB][1]);
        rm1_ky <= sat_of(dy_quo[DivB], dy_side[DivB][0]);
        {rm1_dx, rm1_dy, rm1_flt, rm1_cal} <= dx_side[DivB][SideB-1:1];
    end

    // stage M2: products (raw mode passes samples)
    logic rm2_vld, rm2_flt;
    logic signed [VecB-1:0] rm2_x, rm2_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rm2_vld <= 1'b0;
        else rm2_vld <= rm1_vld;
        rm2_flt <= rm1_flt;
        if (rm1_cal) begin
            rm2_x <= VecB'(rm1_dx * rm1_kx);
            rm2_y <= VecB'(rm1_dy * rm1_ky);
        end else begin
            rm2_x <= VecB'(rm1_dx);
            rm2_y <= VecB'(rm1_dy);
        end
    end

    // prerotation: a = y, b = x when y >= 0; else a quarter turn, z starts at +/-90 degrees
    logic rp_vld;
    logic signed [VecB-1:0] rp_a, rp_b;
    logic signed [AngBits-1:0] rp_z;
    logic [1:0] rp_flags;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rp_vld <= 1'b0;
        else rp_vld <= rm2_vld;
        rp_flags <= {rm2_flt, rm2_x == '0 && rm2_y == '0};
        if (rm2_y[VecB-1]) begin
            if (!rm2_x[VecB-1]) begin
                rp_a <= rm2_x; rp_b <= -rm2_y; rp_z <= Ang90;
            end else begin
                rp_a <= -rm2_x; rp_b <= rm2_y; rp_z <= -Ang90;
            end
        end else begin
            rp_a <= rm2_y; rp_b <= rm2_x; rp_z <= '0;
        end
    end

    logic                  cv [0:CORDIC_STAGES];
    logic signed [VecB-1:0] ca [0:CORDIC_STAGES], cb [0:CORDIC_STAGES];
    logic signed [AngBits-1:0] cz [0:CORDIC_STAGES];
    logic [1:0]            cf [0:CORDIC_STAGES];
    assign cv[0] = rp_vld; assign ca[0] = rp_a; assign cb[0] = rp_b;
    assign cz[0] = rp_z;   assign cf[0] = rp_flags;
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cor
        chmc_cordic_cell #(.VecBits(VecB), .Stage(s)) u_cell (
            .i_clk, .i_vld(cv[s]), .i_a(ca[s]), .i_b(cb[s]), .i_z(cz[s]),
            .i_flags(cf[s]), .o_vld(cv[s+1]), .o_a(ca[s+1]), .o_b(cb[s+1]),
            .o_z(cz[s+1]), .o_flags(cf[s+1]));
    end
    logic [CORDIC_STAGES-1:0] r_csh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_csh <= '0;
        else r_csh <= {r_csh[CORDIC_STAGES-2:0], rp_vld};
    end

    // rounding: floor((z + 512) / 1024), clamped; zero on span fault or zero vector
    logic signed [AngBits-1:0] w_zr;
    logic signed [AngBits-11:0] w_q;
    always_comb begin
        w_zr = cz[CORDIC_STAGES] + AngBits'(512);
        w_q  = (AngBits-10)'(w_zr >>> 10);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else o_done <= r_csh[CORDIC_STAGES-1] && cv[CORDIC_STAGES];
        o_span_fault <= cf[CORDIC_STAGES][1];
        if (cf[CORDIC_STAGES][1] || cf[CORDIC_STAGES][0]) o_heading <= '0;
        else if (w_q > (AngBits-10)'(HeadMax)) o_heading <= HeadMax;
        else if (w_q < -(AngBits-10)'(HeadMax)) o_heading <= -HeadMax;
        else o_heading <= HeadBits'(w_q);
    end

    `CHK_IMPL(a_fault_zero, i_clk, i_rst_n, o_done && o_span_fault, o_heading == '0)
    `CHK_IMPL(a_head_rng, i_clk, i_rst_n, o_done,
              o_heading <= HeadMax && o_heading >= -HeadMax)
    `CHK_NEXT(a_cfg_cal, i_clk, i_rst_n, w_wr && w_idx == RegCal, r_cal == $past(pwdata[0]))
endmodule
